@@ rtl/core/wlfa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the weighted line fit accumulator.
package wlfa_pkg;

  localparam int MAX_POINTS  = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int WEIGHT_BITS = 8;
  localparam int FRAC_SHIFT  = 16;

  // Sample counter saturates at MAX_POINTS + 1.
  localparam int CNT_W  = $clog2(MAX_POINTS + 2);
  // Moment sum widths.
  localparam int SW_W   = 21;
  localparam int SX_W   = 37;
  localparam int SXX_W  = 52;
  // First products in the accumulator pipeline.
  localparam int WX_W   = SAMPLE_BITS + WEIGHT_BITS + 1;
  localparam int XX_W   = 2 * SAMPLE_BITS;
  localparam int WXX_W  = XX_W + WEIGHT_BITS + 1;

  // Fit datapath word width and iteration counts.
  localparam int BW       = 160;
  localparam int MB       = 56;
  localparam int STEP_W   = 8;
  localparam int SQ_TOP   = 46;
  localparam int SQ_STEPS = 24;

  // Queue of finished sets between accumulator and fit engine.
  localparam int QD     = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic [WEIGHT_BITS-1:0]        sample_weight;
    logic                          last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] offset;
    logic [47:0]        residual_sum;
    logic [23:0]        rms_residual;
    logic               degenerate;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic [SW_W-1:0]  sum_w;
    logic [SX_W-1:0]  sum_wx;
    logic [SX_W-1:0]  sum_wy;
    logic [SXX_W-1:0] sum_wxx;
    logic [SXX_W-1:0] sum_wxy;
    logic [SXX_W-1:0] sum_wyy;
    logic             overflow;
  } snap_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

endpackage

@@ rtl/core/wlfa_arith.sv @@
`timescale 1ns / 1ps
// Shared iterative unit: shift-add multiply, restoring divide, integer square root.
module wlfa_arith import wlfa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  arith_req_t      req_i,
  input  logic [BW-1:0]   opa_i,
  input  logic [BW-1:0]   opb_i,
  output logic            done_o,
  output logic [BW-1:0]   result_o
);

  logic              busy_q, done_q, neg_q;
  arith_op_e         op_q;
  logic [STEP_W-1:0] cnt_q;
  logic [BW-1:0]     x_q, y_q, acc_q;
  logic [BW:0]       rem_q;

  logic [BW-1:0] abs_a, abs_b, x_d, y_d, acc_d, trial;
  logic [BW:0]   rem_sh, rem_d;
  logic          ge;

  assign abs_a = opa_i[BW-1] ? (~opa_i + 1'b1) : opa_i;
  assign abs_b = opb_i[BW-1] ? (~opb_i + 1'b1) : opb_i;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    rem_sh = {rem_q[BW-1:0], x_q[BW-1]};
    trial  = acc_q + y_q;
    ge     = 1'b0;
    case (op_q)
      OP_MUL: begin
        acc_d = y_q[0] ? (acc_q + x_q) : acc_q;
        x_d   = x_q << 1;
        y_d   = y_q >> 1;
      end
      OP_DIV: begin
        ge    = rem_sh >= {1'b0, y_q};
        rem_d = ge ? (rem_sh - {1'b0, y_q}) : rem_sh;
        acc_d = {acc_q[BW-2:0], ge};
        x_d   = x_q << 1;
      end
      OP_SQRT: begin
        ge    = x_q >= trial;
        x_d   = ge ? (x_q - trial) : x_q;
        acc_d = ge ? ((acc_q >> 1) + y_q) : (acc_q >> 1);
        y_d   = y_q >> 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        case (req_i.op)
          OP_MUL:  cnt_q <= STEP_W'(MB);
          OP_DIV:  cnt_q <= STEP_W'(BW);
          default: cnt_q <= STEP_W'(SQ_STEPS);
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      rem_q <= '0;
      neg_q <= opa_i[BW-1] ^ opb_i[BW-1];
      case (req_i.op)
        OP_MUL: begin
          x_q <= abs_a;
          y_q <= BW'(abs_b[MB-1:0]);
        end
        OP_DIV: begin
          x_q <= opa_i;
          y_q <= opb_i;
        end
        default: begin
          x_q <= opa_i;
          y_q <= BW'(1) << SQ_TOP;
        end
      endcase
    end else if (busy_q) begin
      x_q   <= x_d;
      y_q   <= y_d;
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = (op_q == OP_MUL && neg_q) ? (~acc_q + 1'b1) : acc_q;

endmodule

@@ rtl/core/wlfa_front.sv @@
`timescale 1ns / 1ps
// Accumulator front end: takes samples and builds the six moment sums.
module wlfa_front import wlfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  input  logic [QCNT_W-1:0] q_count_i,
  output logic              push_o,
  output snap_t             push_data_o
);

  logic     a_vld_q;
  in_item_t a_item_q;

  logic                          b_vld_q, b_last_q;
  logic [WEIGHT_BITS-1:0]        b_w_q;
  logic signed [WX_W-1:0]        b_wx_q, b_wy_q;
  logic signed [XX_W-1:0]        b_xx_q, b_xy_q, b_yy_q;

  logic [SW_W-1:0]  sum_w_q, sum_w_d;
  logic [SX_W-1:0]  sum_wx_q, sum_wx_d, sum_wy_q, sum_wy_d;
  logic [SXX_W-1:0] sum_wxx_q, sum_wxx_d, sum_wxy_q, sum_wxy_d, sum_wyy_q, sum_wyy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [QCNT_W:0]          pend;
  logic                     accept, add_en;
  logic signed [WEIGHT_BITS:0] wa, wb;
  logic signed [WXX_W-1:0]  wxx, wxy, wyy;

  // Count sets already in the pipe so a last item always finds queue room.
  assign pend = (QCNT_W+1)'(q_count_i)
              + (QCNT_W+1)'(a_vld_q & a_item_q.last_sample)
              + (QCNT_W+1)'(b_vld_q & b_last_q);
  assign in_stall_o = pend >= (QCNT_W+1)'(QD);
  assign accept     = in_valid_i & ~in_stall_o;

  assign wa  = $signed({1'b0, a_item_q.sample_weight});
  assign wb  = $signed({1'b0, b_w_q});
  assign wxx = wb * b_xx_q;
  assign wxy = wb * b_xy_q;
  assign wyy = wb * b_yy_q;

  assign add_en    = cnt_q < CNT_W'(MAX_POINTS);
  assign sum_w_d   = sum_w_q   + (add_en ? SW_W'(b_w_q)  : '0);
  assign sum_wx_d  = sum_wx_q  + (add_en ? SX_W'(b_wx_q) : '0);
  assign sum_wy_d  = sum_wy_q  + (add_en ? SX_W'(b_wy_q) : '0);
  assign sum_wxx_d = sum_wxx_q + (add_en ? SXX_W'(wxx)   : '0);
  assign sum_wxy_d = sum_wxy_q + (add_en ? SXX_W'(wxy)   : '0);
  assign sum_wyy_d = sum_wyy_q + (add_en ? SXX_W'(wyy)   : '0);
  assign cnt_d     = (cnt_q <= CNT_W'(MAX_POINTS)) ? (cnt_q + 1'b1) : cnt_q;

  assign push_o               = b_vld_q & b_last_q;
  assign push_data_o.sum_w    = sum_w_d;
  assign push_data_o.sum_wx   = sum_wx_d;
  assign push_data_o.sum_wy   = sum_wy_d;
  assign push_data_o.sum_wxx  = sum_wxx_d;
  assign push_data_o.sum_wxy  = sum_wxy_d;
  assign push_data_o.sum_wyy  = sum_wyy_d;
  assign push_data_o.overflow = cnt_d > CNT_W'(MAX_POINTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      b_last_q  <= 1'b0;
      sum_w_q   <= '0;
      sum_wx_q  <= '0;
      sum_wy_q  <= '0;
      sum_wxx_q <= '0;
      sum_wxy_q <= '0;
      sum_wyy_q <= '0;
      cnt_q     <= '0;
    end else begin
      a_vld_q  <= accept;
      b_vld_q  <= a_vld_q;
      b_last_q <= a_vld_q & a_item_q.last_sample;
      if (b_vld_q) begin
        if (b_last_q) begin
          // Set is handed to the queue; start the next one empty.
          sum_w_q   <= '0;
          sum_wx_q  <= '0;
          sum_wy_q  <= '0;
          sum_wxx_q <= '0;
          sum_wxy_q <= '0;
          sum_wyy_q <= '0;
          cnt_q     <= '0;
        end else begin
          sum_w_q   <= sum_w_d;
          sum_wx_q  <= sum_wx_d;
          sum_wy_q  <= sum_wy_d;
          sum_wxx_q <= sum_wxx_d;
          sum_wxy_q <= sum_wxy_d;
          sum_wyy_q <= sum_wyy_d;
          cnt_q     <= cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_item_q <= in_item_i;
    end
    if (a_vld_q) begin
      b_w_q  <= a_item_q.sample_weight;
      b_wx_q <= wa * a_item_q.sample_x;
      b_wy_q <= wa * a_item_q.sample_y;
      b_xx_q <= a_item_q.sample_x * a_item_q.sample_x;
      b_xy_q <= a_item_q.sample_x * a_item_q.sample_y;
      b_yy_q <= a_item_q.sample_y * a_item_q.sample_y;
    end
  end

endmodule

@@ rtl/core/wlfa_queue.sv @@
`timescale 1ns / 1ps
// Small queue of finished moment sets between accumulator and fit engine.
module wlfa_queue import wlfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  snap_t             data_i,
  input  logic              pop_i,
  output snap_t             data_o,
  output logic [QCNT_W-1:0] count_o
);

  snap_t             mem_q [QD];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

@@ rtl/core/wlfa_back.sv @@
`timescale 1ns / 1ps
// Fit engine: sequences determinant, numerators, divides and root for one set.
module wlfa_back import wlfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [QCNT_W-1:0] q_count_i,
  input  snap_t             head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_M0   = 5'd1;
  localparam logic [4:0] ST_M1   = 5'd2;
  localparam logic [4:0] ST_M2   = 5'd3;
  localparam logic [4:0] ST_M3   = 5'd4;
  localparam logic [4:0] ST_M4   = 5'd5;
  localparam logic [4:0] ST_M5   = 5'd6;
  localparam logic [4:0] ST_CHK  = 5'd7;
  localparam logic [4:0] ST_M6   = 5'd8;
  localparam logic [4:0] ST_M7   = 5'd9;
  localparam logic [4:0] ST_M8   = 5'd10;
  localparam logic [4:0] ST_DV0  = 5'd11;
  localparam logic [4:0] ST_DV1  = 5'd12;
  localparam logic [4:0] ST_RCHK = 5'd13;
  localparam logic [4:0] ST_DV2  = 5'd14;
  localparam logic [4:0] ST_M9   = 5'd15;
  localparam logic [4:0] ST_DV3  = 5'd16;
  localparam logic [4:0] ST_SQ   = 5'd17;
  localparam logic [4:0] ST_EMIT = 5'd18;

  localparam logic [BW-1:0] MAG_MIN = BW'(64'h8000_0000);
  localparam logic [BW-1:0] MAG_MAX = BW'(64'h7FFF_FFFF);
  localparam logic [BW-1:0] LIM48   = BW'(64'hFFFF_FFFF_FFFF);

  logic [4:0]    state_q;
  logic          issued_q;
  snap_t         snap_q;
  logic [BW-1:0] d_q, a_q, b_q, t_q, r_q;
  logic [31:0]   slope_q, offset_q;
  logic [47:0]   resid_q;
  logic [23:0]   rms_q;
  logic          degen_q;
  logic          out_valid_q;
  out_item_t     out_item_q;

  arith_req_t    req;
  logic [BW-1:0] opa, opb, p;
  logic          done, is_op, emit;
  logic [BW-1:0] s, sx, sy, sxx, sxy, syy, abs_a, abs_b;

  function automatic logic [31:0] sat32(input logic neg, input logic [BW-1:0] q);
    logic [31:0] v;
    if (neg) begin
      v = (q >= MAG_MIN) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end else begin
      v = (q > MAG_MAX) ? 32'h7FFF_FFFF : q[31:0];
    end
    return v;
  endfunction

  assign s   = BW'(snap_q.sum_w);
  assign sx  = {{(BW-SX_W){snap_q.sum_wx[SX_W-1]}}, snap_q.sum_wx};
  assign sy  = {{(BW-SX_W){snap_q.sum_wy[SX_W-1]}}, snap_q.sum_wy};
  assign sxx = {{(BW-SXX_W){snap_q.sum_wxx[SXX_W-1]}}, snap_q.sum_wxx};
  assign sxy = {{(BW-SXX_W){snap_q.sum_wxy[SXX_W-1]}}, snap_q.sum_wxy};
  assign syy = {{(BW-SXX_W){snap_q.sum_wyy[SXX_W-1]}}, snap_q.sum_wyy};

  assign abs_a = a_q[BW-1] ? (~a_q + 1'b1) : a_q;
  assign abs_b = b_q[BW-1] ? (~b_q + 1'b1) : b_q;

  assign is_op = state_q inside {ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
                                 ST_M8, ST_M9, ST_DV0, ST_DV1, ST_DV2, ST_DV3, ST_SQ};

  assign emit = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // Second operand of a multiply is always the narrow one.
  always_comb begin
    req.op = OP_MUL;
    opa    = '0;
    opb    = '0;
    case (state_q)
      ST_M0: begin opa = sxx; opb = s;   end
      ST_M1: begin opa = sx;  opb = sx;  end
      ST_M2: begin opa = sxy; opb = s;   end
      ST_M3: begin opa = sx;  opb = sy;  end
      ST_M4: begin opa = sxx; opb = sy;  end
      ST_M5: begin opa = sxy; opb = sx;  end
      ST_M6: begin opa = d_q; opb = syy; end
      ST_M7: begin opa = a_q; opb = sxy; end
      ST_M8: begin opa = b_q; opb = sy;  end
      ST_M9: begin opa = d_q; opb = s;   end
      ST_DV0: begin
        req.op = OP_DIV;
        opa    = (abs_a << (FRAC_SHIFT + 1)) + d_q;
        opb    = d_q << 1;
      end
      ST_DV1: begin
        req.op = OP_DIV;
        opa    = (abs_b << (FRAC_SHIFT + 1)) + d_q;
        opb    = d_q << 1;
      end
      ST_DV2: begin
        req.op = OP_DIV;
        opa    = r_q;
        opb    = d_q;
      end
      ST_DV3: begin
        req.op = OP_DIV;
        opa    = r_q << FRAC_SHIFT;
        opb    = t_q;
      end
      ST_SQ: begin
        req.op = OP_SQRT;
        opa    = t_q;
      end
      default: ;
    endcase
    req.start = is_op & ~issued_q;
  end

  wlfa_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .opa_i    (opa),
    .opb_i    (opb),
    .done_o   (done),
    .result_o (p)
  );

  assign pop_o = (state_q == ST_IDLE) && (q_count_i != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (is_op) begin
        if (!issued_q) begin
          issued_q <= 1'b1;
        end else if (done) begin
          issued_q <= 1'b0;
          case (state_q)
            ST_M0:   state_q <= ST_M1;
            ST_M1:   state_q <= ST_M2;
            ST_M2:   state_q <= ST_M3;
            ST_M3:   state_q <= ST_M4;
            ST_M4:   state_q <= ST_M5;
            ST_M5:   state_q <= ST_CHK;
            ST_M6:   state_q <= ST_M7;
            ST_M7:   state_q <= ST_M8;
            ST_M8:   state_q <= ST_DV0;
            ST_DV0:  state_q <= ST_DV1;
            ST_DV1:  state_q <= ST_RCHK;
            ST_DV2:  state_q <= ST_M9;
            ST_M9:   state_q <= ST_DV3;
            ST_DV3:  state_q <= (p > LIM48) ? ST_EMIT : ST_SQ;
            default: state_q <= ST_EMIT;
          endcase
        end
      end else begin
        case (state_q)
          ST_IDLE: begin
            if (q_count_i != '0) begin
              state_q <= ST_M0;
            end
          end
          ST_CHK: begin
            state_q <= (d_q == '0) ? ST_EMIT : ST_M6;
          end
          ST_RCHK: begin
            state_q <= (r_q[BW-1] || s == '0) ? ST_EMIT : ST_DV2;
          end
          ST_EMIT: begin
            if (emit) begin
              state_q <= ST_IDLE;
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_count_i != '0) begin
          snap_q   <= head_i;
          slope_q  <= '0;
          offset_q <= '0;
          resid_q  <= '0;
          rms_q    <= '0;
          degen_q  <= 1'b0;
        end
      end
      ST_CHK: begin
        if (d_q == '0) begin
          degen_q <= 1'b1;
        end else if (d_q[BW-1]) begin
          // Keep the determinant positive; flip the numerators with it.
          d_q <= ~d_q + 1'b1;
          a_q <= ~a_q + 1'b1;
          b_q <= ~b_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_item_q.slope        <= slope_q;
          out_item_q.offset       <= offset_q;
          out_item_q.residual_sum <= resid_q;
          out_item_q.rms_residual <= rms_q;
          out_item_q.degenerate   <= degen_q;
          out_item_q.overflow     <= snap_q.overflow;
        end
      end
      default: begin
        if (issued_q && done) begin
          case (state_q)
            ST_M0:  t_q <= p;
            ST_M1:  d_q <= t_q - p;
            ST_M2:  t_q <= p;
            ST_M3:  a_q <= t_q - p;
            ST_M4:  t_q <= p;
            ST_M5:  b_q <= t_q - p;
            ST_M6:  t_q <= p;
            ST_M7:  t_q <= t_q - p;
            ST_M8:  r_q <= t_q - p;
            ST_DV0: slope_q  <= sat32(a_q[BW-1], p);
            ST_DV1: offset_q <= sat32(b_q[BW-1], p);
            ST_DV2: resid_q  <= (p > LIM48) ? 48'hFFFF_FFFF_FFFF : p[47:0];
            ST_M9:  t_q <= p;
            ST_DV3: begin
              if (p > LIM48) begin
                rms_q <= 24'hFF_FFFF;
              end else begin
                t_q <= p;
              end
            end
            ST_SQ:  rms_q <= p[23:0];
            default: ;
          endcase
        end
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/core/weighted_line_fit_accumulator.sv @@
`timescale 1ns / 1ps
// Weighted least-squares line fit accumulator (top level).
// Samples are taken one per cycle into a three-stage multiply-accumulate pipe that builds the
// six moment sums; the item marked last closes the set, and its sums go into a four-entry queue.
// A fit engine takes sets from the queue and computes slope, offset, residual and RMS residual
// with one shared iterative unit: ten shift-add multiplies, four restoring divides and a square
// root per set, fewer for a degenerate set. Input stalls only when the queue cannot take another
// finished set. The result sits in an output register, so the engine works on the next set while
// a result waits to be taken.
module weighted_line_fit_accumulator import wlfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic              push, pop;
  snap_t             push_data, head;
  logic [QCNT_W-1:0] q_count;

  wlfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  wlfa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (head),
    .count_o (q_count)
  );

  wlfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_count_i   (q_count),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
